// ===== rtl/core/btn_deb_pkg.sv =====
`default_nettype none

package btn_deb_pkg;

   // Request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOGGLE_EN   = 3'd4;

   // Register reset values
   localparam logic [9:0] INTERVAL_RST    = 10'd10;
   localparam logic [7:0] HIGH_THRESH_RST = 8'd223;
   localparam logic [7:0] LOW_THRESH_RST  = 8'd32;
   localparam logic [7:0] AVG_FULL        = 8'd255;

   // Debounce phase, one-hot
   typedef enum logic [3:0] {
      PH_RELEASED = 4'b0001,
      PH_DOWN     = 4'b0010,
      PH_PRESSED  = 4'b0100,
      PH_UP       = 4'b1000
   } phase_type;

   // Reported button state
   typedef enum logic [2:0] {
      ST_STOPPED  = 3'd0,
      ST_RELEASED = 3'd1,
      ST_DOWN     = 3'd2,
      ST_PRESSED  = 3'd3,
      ST_UP       = 3'd4
   } btn_state_type;

   // Event codes
   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_DOWN    = 2'd1,
      EV_PRESSED = 2'd2,
      EV_UP      = 2'd3
   } event_type;

endpackage

`default_nettype wire

// ===== rtl/core/button_debounce_fsm.sv =====
`default_nettype none

// A request transfer writes its result into the output register, which drives the result channel.
// Throughput: one request per cycle; the state update is a single registered pass.
// A result transfer frees the output register, so a new request can transfer in that
// same cycle; while a result waits, req_ready stays low.
// Reset (synchronous, active high): stopped, average 0, phase released, times 0,
// toggle 0, registers at their defaults, no result pending.
module button_debounce_fsm #(
   parameter int unsigned TIME_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [1:0]                        req_type,
   input  wire                               req_pin_level,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [2:0]                        rsp_button_state,
   output logic [1:0]                        rsp_event_code,
   output logic [31:0]                       rsp_press_duration,
   output logic [31:0]                       rsp_pressed_time,
   output logic                              rsp_toggle_value,
   output logic                              rsp_toggle_changed,
   // configuration writes
   input  wire                               csr_we,
   input  wire  [btn_deb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [btn_deb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import btn_deb_pkg::*;

   // configuration
   logic                 invert_ff;
   logic [9:0]           interval_ff;
   logic [7:0]           high_thresh_ff;
   logic [7:0]           low_thresh_ff;
   logic                 toggle_en_ff;

   // block state
   logic                 running_ff,   running_in;
   logic [7:0]           avg_ff,       avg_in;
   phase_type            phase_ff,     phase_in;
   logic [TIME_BITS-1:0] now_ff,       now_in;
   logic [TIME_BITS-1:0] last_upd_ff,  last_upd_in;
   logic [TIME_BITS-1:0] press_st_ff,  press_st_in;
   logic                 toggle_ff,    toggle_in;

   // result register
   logic                 rsp_valid_ff;
   btn_state_type        state_ff,     state_in;
   event_type            event_ff,     event_in;
   logic [31:0]          duration_ff,  duration_in;
   logic [31:0]          held_ff,      held_in;
   logic                 changed_ff,   changed_in;

   // combinational helpers
   logic                 accept;
   logic                 level;
   logic [TIME_BITS-1:0] now_tick;
   logic [TIME_BITS-1:0] since_upd;
   logic                 upd_due;
   logic [9:0]           avg_sum;
   logic [7:0]           avg_new;
   logic                 above_high;
   logic                 below_low;
   logic [TIME_BITS-1:0] duration_t;
   logic [TIME_BITS-1:0] held_t;
   logic [63:0]          duration_w;
   logic [63:0]          held_w;

   // the output register frees up when its result is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign level     = req_pin_level ^ invert_ff;
   assign now_tick  = now_ff + TIME_BITS'(1);
   assign since_upd = now_tick - last_upd_ff;
   assign upd_due   = running_ff && (since_upd > TIME_BITS'(interval_ff));

   // 3*avg + 255*level + 2 peaks at 1022, fits 10 bits
   assign avg_sum    = {2'b00, avg_ff} + {1'b0, avg_ff, 1'b0}
                     + (level ? {2'b00, AVG_FULL} : 10'd0) + 10'd2;
   assign avg_new    = avg_sum[9:2];
   assign above_high = avg_new > high_thresh_ff;
   assign below_low  = avg_new < low_thresh_ff;

   always_comb begin
      running_in  = running_ff;
      avg_in      = avg_ff;
      phase_in    = phase_ff;
      now_in      = now_ff;
      last_upd_in = last_upd_ff;
      press_st_in = press_st_ff;
      toggle_in   = toggle_ff;
      event_in    = EV_NONE;
      duration_t  = '0;
      changed_in  = 1'b0;

      case (req_type)
         REQ_TICK: begin
            // clock runs even while stopped
            now_in = now_tick;
            if (upd_due) begin
               last_upd_in = now_tick;
               avg_in      = avg_new;
               // first matching check wins: down, pressed, up, released
               case (phase_ff)
                  PH_RELEASED: begin
                     if (above_high) begin
                        press_st_in = now_tick;
                        phase_in    = PH_DOWN;
                        event_in    = EV_DOWN;
                        if (toggle_en_ff) begin
                           toggle_in  = !toggle_ff;
                           changed_in = 1'b1;
                        end
                     end
                  end
                  PH_DOWN: begin
                     if (above_high) begin
                        phase_in = PH_PRESSED;
                        event_in = EV_PRESSED;
                     end else if (below_low) begin
                        phase_in   = PH_UP;
                        event_in   = EV_UP;
                        duration_t = now_tick - press_st_ff;
                     end
                  end
                  PH_PRESSED: begin
                     if (below_low) begin
                        phase_in   = PH_UP;
                        event_in   = EV_UP;
                        duration_t = now_tick - press_st_ff;
                     end
                  end
                  PH_UP: begin
                     if (below_low) begin
                        phase_in = PH_RELEASED;
                     end
                  end
                  default: ;
               endcase
            end
         end
         REQ_START: begin
            // average snaps to the full-scale pin level
            avg_in     = level ? AVG_FULL : 8'd0;
            running_in = 1'b1;
         end
         REQ_STOP: begin
            running_in = 1'b0;
         end
         default: ;
      endcase

      // held time follows the post-update phase, also while stopped
      held_t = (phase_in == PH_PRESSED) ? (now_in - press_st_in) : '0;

      if (!running_in) begin
         state_in = ST_STOPPED;
      end else begin
         case (phase_in)
            PH_RELEASED: state_in = ST_RELEASED;
            PH_DOWN:     state_in = ST_DOWN;
            PH_PRESSED:  state_in = ST_PRESSED;
            PH_UP:       state_in = ST_UP;
            default:     state_in = ST_STOPPED;
         endcase
      end
   end

   // reported times are the low 32 bits of the time base
   assign duration_w  = 64'(duration_t);
   assign held_w      = 64'(held_t);
   assign duration_in = duration_w[31:0];
   assign held_in     = held_w[31:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff      <= 1'b0;
         interval_ff    <= INTERVAL_RST;
         high_thresh_ff <= HIGH_THRESH_RST;
         low_thresh_ff  <= LOW_THRESH_RST;
         toggle_en_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INVERT:      invert_ff      <= csr_wdata[0];
            CSR_INTERVAL:    interval_ff    <= csr_wdata[9:0];
            CSR_HIGH_THRESH: high_thresh_ff <= csr_wdata[7:0];
            CSR_LOW_THRESH:  low_thresh_ff  <= csr_wdata[7:0];
            CSR_TOGGLE_EN:   toggle_en_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // block state, advanced on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         avg_ff      <= 8'd0;
         phase_ff    <= PH_RELEASED;
         now_ff      <= '0;
         last_upd_ff <= '0;
         press_st_ff <= '0;
         toggle_ff   <= 1'b0;
      end else if (accept) begin
         running_ff  <= running_in;
         avg_ff      <= avg_in;
         phase_ff    <= phase_in;
         now_ff      <= now_in;
         last_upd_ff <= last_upd_in;
         press_st_ff <= press_st_in;
         toggle_ff   <= toggle_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         state_ff    <= state_in;
         event_ff    <= event_in;
         duration_ff <= duration_in;
         held_ff     <= held_in;
         changed_ff  <= changed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_button_state   = state_ff;
   assign rsp_event_code     = event_ff;
   assign rsp_press_duration = duration_ff;
   assign rsp_pressed_time   = held_ff;
   assign rsp_toggle_value   = toggle_ff;
   assign rsp_toggle_changed = changed_ff;

   // every request transfer leaves a result pending
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("no result after request transfer");

   // a toggle flip only comes with a down event
   a_toggle_on_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_toggle_changed) |-> (rsp_event_code == EV_DOWN))
      else $error("toggle flipped without down event");

   // a duration is only reported with an up event
   a_duration_on_up: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_press_duration != 32'd0) |-> (rsp_event_code == EV_UP))
      else $error("press duration without up event");

   // events only happen while running
   a_event_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code != EV_NONE) |-> (rsp_button_state != ST_STOPPED))
      else $error("event reported while stopped");

   // held time only while pressed (or hidden under stopped)
   a_held_pressed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pressed_time != 32'd0)
         |-> (rsp_button_state == ST_PRESSED || rsp_button_state == ST_STOPPED))
      else $error("pressed time outside pressed state");

endmodule

`default_nettype wire
